// File: rtl/core/stable_top_k_select_defines.svh
// Assertion macros for the top-k selector.
// No dependencies.
`ifndef STABLE_TOP_K_SELECT_DEFINES_SVH
`define STABLE_TOP_K_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define TKS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TKS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TKS_ASSERT(label, clk, rst_n, prop, msg)
`define TKS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/tks_pkg.sv
// Package for the top-k selector: widths, constants, order key.
// No dependencies.
package tks_pkg;
    localparam int unsigned DistW  = 32;
    localparam int unsigned IdW    = 31;
    localparam int unsigned RankW  = 5;
    localparam int unsigned KW     = 6;
    localparam int unsigned MaxNbr = 32;
    localparam logic [KW-1:0] KReset = 6'd5;

    function automatic logic [DistW-1:0] order_key(input logic [DistW-1:0] b);
        logic [DistW-1:0] v;
        v = (b == 32'h8000_0000) ? '0 : b;
        return v[DistW-1] ? ~v : (v | 32'h8000_0000);
    endfunction
endpackage

// File: rtl/core/tks_cell.sv
// One slot of the sorted chain: holds an entry, compares, shifts.
// Depends on tks_pkg.
module tks_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ins,
    input  logic                      i_clr,
    input  logic                      i_en,
    input  logic [tks_pkg::DistW-1:0] i_dist,
    input  logic [tks_pkg::DistW-1:0] i_key,
    input  logic [tks_pkg::IdW-1:0]   i_id,
    input  logic                      i_prev_gt,
    input  logic                      i_prev_vld,
    input  logic [tks_pkg::DistW-1:0] i_prev_dist,
    input  logic [tks_pkg::IdW-1:0]   i_prev_id,
    output logic                      o_gt,
    output logic                      o_vld,
    output logic [tks_pkg::DistW-1:0] o_dist,
    output logic [tks_pkg::IdW-1:0]   o_id
);
    import tks_pkg::*;
    logic r_vld;
    logic [DistW-1:0] r_dist;
    logic [IdW-1:0] r_id;

    // greater, or empty: the new item lands at or before this slot
    assign o_gt   = !r_vld || (order_key(r_dist) > i_key);
    assign o_vld  = r_vld;
    assign o_dist = r_dist;
    assign o_id   = r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= 1'b0;
        end else if (i_ins) begin
            if (!i_en) begin
                r_vld <= 1'b0;
            end else if (o_gt && !i_prev_gt) begin
                r_vld  <= 1'b1;
                r_dist <= i_dist;
                r_id   <= i_id;
            end else if (o_gt && i_prev_gt) begin
                r_vld  <= i_prev_vld;
                r_dist <= i_prev_dist;
                r_id   <= i_prev_id;
            end
        end
    end
endmodule

// File: rtl/core/stable_top_k_select.sv
// Top-k selector: configuration, chain of slot cells, ordered readout.
// Depends on tks_pkg, tks_cell and stable_top_k_select_defines.svh.
//
//  channel | valid       | ready       | payload
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_data
//  in      | i_in_valid  | o_in_ready  | distance_bits, point_id, last_item
//  out     | o_out_valid | i_out_ready | rank, kept_distance, kept_id, last_result
//
// One item a cycle, while no drain holds input off, is inserted into the chain in parallel compare and shift.
// An item marked last then drains the chain, one entry per out transfer,
// and input is held off until the final entry leaves; the chain is cleared.
// Reset empties all slots and sets k to 5.
`include "stable_top_k_select_defines.svh"
module stable_top_k_select #(
    parameter int unsigned MAX_NEIGHBOURS = tks_pkg::MaxNbr
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tks_pkg::KW-1:0]    i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [tks_pkg::DistW-1:0] i_distance_bits,
    input  logic [tks_pkg::IdW-1:0]   i_point_id,
    input  logic                      i_last_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [tks_pkg::RankW-1:0] o_rank,
    output logic [tks_pkg::DistW-1:0] o_kept_distance,
    output logic [tks_pkg::IdW-1:0]   o_kept_id,
    output logic                      o_last_result
);
    import tks_pkg::*;
    localparam int unsigned N = MAX_NEIGHBOURS;
    localparam int unsigned CW = $clog2(N + 1);
    localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

    logic [KW-1:0] r_k;
    logic r_drain;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] w_nxt;
    logic [N-1:0] w_gt, w_vld, w_en;
    logic [DistW-1:0] w_dist [N];
    logic [IdW-1:0] w_id [N];
    logic [CW-1:0] w_keff;
    logic w_ins, w_clr, w_out_xfer;
    logic [DistW-1:0] w_key;

    always_comb begin
        if (r_k == '0) w_keff = CW'(1);
        else if (32'(r_k) > N) w_keff = CW'(N);
        else w_keff = CW'(r_k);
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_drain;
    assign w_ins       = i_in_valid && o_in_ready;
    assign w_key       = order_key(i_distance_bits);
    assign o_out_valid = r_drain && (r_rd < CW'(N)) && w_vld[r_rd[IW-1:0]];
    assign w_out_xfer  = o_out_valid && i_out_ready;
    assign o_rank = RankW'(r_rd);
    assign o_kept_distance = w_dist[r_rd[IW-1:0]];
    assign o_kept_id = w_id[r_rd[IW-1:0]];
    assign w_nxt = r_rd + CW'(1);
    assign o_last_result = (w_nxt == CW'(N)) || !w_vld[w_nxt[IW-1:0]];
    assign w_clr = r_drain && (!o_out_valid || (w_out_xfer && o_last_result));

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign w_en[g] = (CW'(g) < w_keff);
            if (g == 0) begin : g_head
                tks_cell u_cell (
                    .i_clk, .i_rst_n, .i_ins(w_ins), .i_clr(w_clr), .i_en(w_en[g]),
                    .i_dist(i_distance_bits), .i_key(w_key), .i_id(i_point_id),
                    .i_prev_gt(1'b0), .i_prev_vld(1'b0), .i_prev_dist('0),
                    .i_prev_id('0), .o_gt(w_gt[g]), .o_vld(w_vld[g]),
                    .o_dist(w_dist[g]), .o_id(w_id[g])
                );
            end else begin : g_body
                tks_cell u_cell (
                    .i_clk, .i_rst_n, .i_ins(w_ins), .i_clr(w_clr), .i_en(w_en[g]),
                    .i_dist(i_distance_bits), .i_key(w_key), .i_id(i_point_id),
                    .i_prev_gt(w_gt[g-1]), .i_prev_vld(w_vld[g-1]),
                    .i_prev_dist(w_dist[g-1]), .i_prev_id(w_id[g-1]),
                    .o_gt(w_gt[g]), .o_vld(w_vld[g]),
                    .o_dist(w_dist[g]), .o_id(w_id[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= KReset;
            r_drain <= 1'b0;
            r_rd    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_k <= i_cfg_data;
            if (w_clr) begin
                r_drain <= 1'b0;
                r_rd    <= '0;
            end else if (w_ins && i_last_item) begin
                r_drain <= 1'b1;
            end else if (w_out_xfer) begin
                r_rd <= r_rd + CW'(1);
            end
        end
    end

    `TKS_ASSERT(a_no_in_drain, i_clk, i_rst_n, r_drain |-> !o_in_ready, "input during drain")
    `TKS_ASSERT(a_out_drain, i_clk, i_rst_n, o_out_valid |-> r_drain, "output outside drain")
    `TKS_ASSERT(a_clr_empty, i_clk, i_rst_n, w_clr |=> !w_vld[0], "chain not cleared")
    `TKS_ASSERT_NR(a_rst, i_clk, !i_rst_n |=> !o_out_valid, "output after reset")
endmodule
